// ===== src/grfd_pkg.sv =====
// grfd_pkg: shared constants and types for the grid ray free distance unit
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package grfd_pkg;
  localparam int GRID_DIM = 256;
  localparam int CW = $clog2(GRID_DIM);
  localparam int DIM_W = CW + 1;
  localparam int MAP_DEPTH = GRID_DIM * GRID_DIM;
  localparam int MAP_AW = 2 * CW;
  localparam int GUARD_W = DIM_W + 2;
  localparam int K_W = DIM_W + 2;
  localparam int PROD_W = K_W + 16;
  localparam int POS_W = 10;
  localparam int D2_W = 18;
  localparam int DIST_W = 17;
  localparam int RAD_W = 34;
  localparam int SQ_ITER = RAD_W / 2;
  localparam int QDEPTH = 4;
  localparam int QAW = $clog2(QDEPTH);
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic             opcode;
    logic [CW-1:0]    cell_x;
    logic [CW-1:0]    cell_y;
    logic             cell_free;
    logic [15:0]      dir_x;
    logic [15:0]      dir_y;
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
  } cmd_t;
endpackage
`default_nettype wire

// ===== src/grfd_front.sv =====
// grfd_front: latches grid size, accepts and queues clamped-size words
// depends on grfd_pkg
`timescale 1ns / 1ps
`default_nettype none
module grfd_front import grfd_pkg::*; (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              cfg_we,
  input  wire              cfg_index,
  input  wire [8:0]        cfg_data,
  input  wire              in_valid,
  output logic             in_ready,
  input  wire              in_opcode,
  input  wire [7:0]        in_cell_x,
  input  wire [7:0]        in_cell_y,
  input  wire              in_cell_free,
  input  wire signed [15:0] in_dir_x,
  input  wire signed [15:0] in_dir_y,
  output logic             q_valid,
  input  wire              q_ready,
  output cmd_t             q_cmd
);
  logic [8:0] w_r, h_r;
  cmd_t mem [QDEPTH];
  logic [QAW-1:0] wp_r, rp_r;
  logic [QAW:0] cnt_r;
  logic [DIM_W-1:0] wc, hc;
  logic push, pop;

  function automatic logic [DIM_W-1:0] clampd(input logic [8:0] r);
    if (r == 9'd0) return DIM_W'(1);
    if ({23'd0, r} > GRID_DIM) return DIM_W'(GRID_DIM);
    return DIM_W'(r);
  endfunction

  assign wc = clampd(w_r);
  assign hc = clampd(h_r);
  assign in_ready = (cnt_r != (QAW+1)'(QDEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_cmd = mem[rp_r];
  assign push = in_valid && in_ready;
  assign pop = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r <= 9'd256;
      h_r <= 9'd256;
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (cfg_we && cfg_index == 1'b0) w_r <= cfg_data;
      if (cfg_we && cfg_index == 1'b1) h_r <= cfg_data;
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (QAW+1)'(push) - (QAW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp_r] <= '{opcode: in_opcode, cell_x: CW'(in_cell_x), cell_y: CW'(in_cell_y),
                     cell_free: in_cell_free, dir_x: in_dir_x, dir_y: in_dir_y,
                     w: wc, h: hc};
    end
  end
endmodule
`default_nettype wire

// ===== src/grfd_sqrt.sv =====
// grfd_sqrt: bit-serial rounded square root of d2 << 16
// depends on grfd_pkg
`timescale 1ns / 1ps
`default_nettype none
module grfd_sqrt import grfd_pkg::*; (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               start,
  input  wire [D2_W-1:0]    d2,
  output logic              busy,
  output logic              done,
  output logic [DIST_W-1:0] root
);
  logic [RAD_W-1:0] n_r, res_r, one_r;
  logic [4:0] it_r;
  logic [RAD_W-1:0] t;
  logic [RAD_W:0] rnd;
  logic [RAD_W-1:0] fin;

  assign t = res_r + one_r;
  assign rnd = {1'b0, res_r} + {{RAD_W{1'b0}}, (n_r > res_r)};
  assign fin = rnd[RAD_W-1:0];
  assign root = (fin > RAD_W'(131071)) ? DIST_W'(131071) : fin[DIST_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy <= 1'b0;
      done <= 1'b0;
      it_r <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        n_r <= {d2, 16'd0};
        res_r <= '0;
        one_r <= RAD_W'(1) << (RAD_W - 2);
        it_r <= '0;
      end else if (busy) begin
        if (n_r >= t) begin
          n_r <= n_r - t;
          res_r <= (res_r >> 1) + one_r;
        end else begin
          res_r <= res_r >> 1;
        end
        one_r <= one_r >> 2;
        it_r <= it_r + 1'b1;
        if (it_r == 5'(SQ_ITER - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== src/grfd_back.sv =====
// grfd_back: map memory, clear sweep, ray walker and result register
// depends on grfd_pkg, grfd_sqrt
`timescale 1ns / 1ps
`default_nettype none
module grfd_back import grfd_pkg::*; (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               q_valid,
  output logic              q_ready,
  input  cmd_t              q_cmd,
  output logic              out_valid,
  input  wire               out_ready,
  output logic [DIST_W-1:0] out_distance,
  output logic [D2_W-1:0]   out_distance_squared,
  output logic signed [POS_W-1:0] out_end_x,
  output logic signed [POS_W-1:0] out_end_y,
  output logic              out_left_grid
);
  localparam logic [2:0] S_CLR = 3'd0, S_IDLE = 3'd1, S_RD = 3'd2, S_CHK = 3'd3,
                         S_SQ = 3'd4, S_OUT = 3'd5, S_MUL = 3'd6;
  logic [2:0] st_r;
  logic mem [MAP_DEPTH];
  logic [MAP_AW-1:0] clr_r;
  logic rd_r;
  logic signed [POS_W-1:0] px_r, py_r, sx_r, sy_r;
  logic [15:0] ax_r, ay_r;
  logic nx_r, ny_r;
  logic [K_W-1:0] kx_r, ky_r;
  logic [GUARD_W-1:0] g_r;
  logic [DIM_W-1:0] w_r, h_r;
  logic left_r;
  logic [PROD_W-1:0] pa_r, pb_r;
  logic [D2_W-1:0] d2_r;
  logic sq_start, sq_busy, sq_done;
  logic [DIST_W-1:0] sq_dist;
  logic we;
  logic [MAP_AW-1:0] wa, ra;
  logic wd;
  logic outside;
  logic signed [POS_W-1:0] dx, dy;
  logic [2*POS_W-1:0] sqx, sqy;
  logic [2*POS_W-1:0] d2f;
  logic out_ld;

  assign q_ready = (st_r == S_IDLE);
  assign outside = px_r < 0 || py_r < 0 || px_r >= $signed({1'b0, w_r}) ||
                   py_r >= $signed({1'b0, h_r});
  assign ra = {py_r[CW-1:0], px_r[CW-1:0]};
  assign dx = px_r - sx_r;
  assign dy = py_r - sy_r;
  assign sqx = (2*POS_W)'(dx) * (2*POS_W)'(dx);
  assign sqy = (2*POS_W)'(dy) * (2*POS_W)'(dy);
  assign d2f = sqx + sqy;
  assign out_ld = (st_r == S_OUT) && (!out_valid || out_ready);

  always_comb begin
    we = 1'b0;
    wa = clr_r;
    wd = 1'b0;
    if (st_r == S_CLR) begin
      we = 1'b1;
    end else if (st_r == S_IDLE && q_valid && q_cmd.opcode == OP_WRITE) begin
      we = 1'b1;
      wa = {q_cmd.cell_y, q_cmd.cell_x};
      wd = q_cmd.cell_free;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_r <= mem[ra];
  end

  assign sq_start = (st_r == S_SQ) && !sq_busy && !sq_done;

  grfd_sqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .start(sq_start),
    .d2(d2_r), .busy(sq_busy), .done(sq_done), .root(sq_dist)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLR;
      clr_r <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_ld) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      case (st_r)
        S_CLR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == '1) st_r <= S_IDLE;
        end
        S_IDLE: begin
          if (q_valid && q_cmd.opcode == OP_QUERY) begin
            px_r <= POS_W'({1'b0, q_cmd.cell_x});
            py_r <= POS_W'({1'b0, q_cmd.cell_y});
            sx_r <= POS_W'({1'b0, q_cmd.cell_x});
            sy_r <= POS_W'({1'b0, q_cmd.cell_y});
            nx_r <= q_cmd.dir_x[15];
            ny_r <= q_cmd.dir_y[15];
            ax_r <= q_cmd.dir_x[15] ? 16'(-q_cmd.dir_x) : q_cmd.dir_x;
            ay_r <= q_cmd.dir_y[15] ? 16'(-q_cmd.dir_y) : q_cmd.dir_y;
            kx_r <= K_W'(1);
            ky_r <= K_W'(1);
            g_r <= '0;
            w_r <= q_cmd.w;
            h_r <= q_cmd.h;
            st_r <= S_RD;
          end
        end
        S_RD: begin
          pa_r <= PROD_W'(kx_r) * PROD_W'(ay_r);
          pb_r <= PROD_W'(ky_r) * PROD_W'(ax_r);
          st_r <= S_CHK;
        end
        S_CHK: begin
          if (outside) begin
            left_r <= 1'b1;
            st_r <= S_MUL;
          end else if (!rd_r) begin
            left_r <= 1'b0;
            st_r <= S_MUL;
          end else if (g_r >= GUARD_W'(2*GRID_DIM+2)) begin
            left_r <= 1'b1;
            st_r <= S_MUL;
          end else begin
            g_r <= g_r + 1'b1;
            if (ax_r != 0 && (ay_r == 0 || pa_r < pb_r)) begin
              kx_r <= kx_r + 1'b1;
              px_r <= nx_r ? px_r - POS_W'(1) : px_r + POS_W'(1);
            end else begin
              ky_r <= ky_r + 1'b1;
              py_r <= ny_r ? py_r - POS_W'(1) : py_r + POS_W'(1);
            end
            st_r <= S_RD;
          end
        end
        S_MUL: begin
          d2_r <= (d2f > (2*POS_W)'(262143)) ? D2_W'(262143) : d2f[D2_W-1:0];
          st_r <= S_SQ;
        end
        S_SQ: begin
          if (sq_done) st_r <= S_OUT;
        end
        S_OUT: begin
          if (out_ld) begin
            out_distance <= sq_dist;
            out_distance_squared <= d2_r;
            out_end_x <= px_r;
            out_end_y <= py_r;
            out_left_grid <= left_r;
            st_r <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== src/grid_ray_free_distance_unit.sv =====
// grid_ray_free_distance_unit: top level of the grid ray free distance unit
// depends on grfd_pkg, grfd_front, grfd_back
`timescale 1ns / 1ps
`default_nettype none
// After reset the whole map is cleared, and during the sweep no word is
// taken from the queue. A map write is done by the back end as it is taken
// from the queue. A query is taken, then for each visited cell the walker
// reads the map and then compares the crossing products; then the distance
// is squared, the bit-serial root is taken and the result is registered.
// A four-word queue lets words arrive while a walk runs.
module grid_ray_free_distance_unit import grfd_pkg::*; (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               cfg_we,
  input  wire               cfg_index,
  input  wire [8:0]         cfg_data,
  input  wire               in_valid,
  output logic              in_ready,
  input  wire               in_opcode,
  input  wire [7:0]         in_cell_x,
  input  wire [7:0]         in_cell_y,
  input  wire               in_cell_free,
  input  wire signed [15:0] in_dir_x,
  input  wire signed [15:0] in_dir_y,
  output logic              out_valid,
  input  wire               out_ready,
  output logic [16:0]       out_distance,
  output logic [17:0]       out_distance_squared,
  output logic signed [9:0] out_end_x,
  output logic signed [9:0] out_end_y,
  output logic              out_left_grid
);
  logic q_valid, q_ready;
  cmd_t q_cmd;

  grfd_front u_front (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready),
    .in_opcode(in_opcode), .in_cell_x(in_cell_x), .in_cell_y(in_cell_y),
    .in_cell_free(in_cell_free), .in_dir_x(in_dir_x), .in_dir_y(in_dir_y),
    .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd)
  );

  grfd_back u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd),
    .out_valid(out_valid), .out_ready(out_ready), .out_distance(out_distance),
    .out_distance_squared(out_distance_squared), .out_end_x(out_end_x),
    .out_end_y(out_end_y), .out_left_grid(out_left_grid)
  );
endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// testbench: regression for grid_ray_free_distance_unit, predicts every ray result
// from its own free-space map copy and checks output words in order
// depends on grfd_pkg and the unit's rtl
`timescale 1ns / 1ps
module testbench;
  import grfd_pkg::*;

  typedef struct {
    logic [16:0] distance;
    logic [17:0] distance_squared;
    logic [9:0]  end_x;
    logic [9:0]  end_y;
    logic        left_grid;
  } ray_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [8:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_opcode = 1'b0;
  logic [7:0] in_cell_x = '0;
  logic [7:0] in_cell_y = '0;
  logic in_cell_free = 1'b0;
  logic signed [15:0] in_dir_x = '0;
  logic signed [15:0] in_dir_y = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [16:0] out_distance;
  logic [17:0] out_distance_squared;
  logic signed [9:0] out_end_x;
  logic signed [9:0] out_end_y;
  logic out_left_grid;

  bit free_cells [0:MAP_DEPTH-1];
  int unsigned cols_reg = 256;
  int unsigned rows_reg = 256;
  ray_result_t pending_rays[$];
  int errors = 0;
  int idle_cycles = 0;
  bit sink_hold = 1'b0;
  bit calm = 1'b0;

  grid_ray_free_distance_unit dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int unsigned clamp_dim(int unsigned r);
    if (r < 1) return 1;
    if (r > GRID_DIM) return GRID_DIM;
    return r;
  endfunction

  function automatic longint unsigned int_root(longint unsigned n);
    longint unsigned res = 0;
    longint unsigned one = 64'd1 << 62;
    while (one > n) one >>= 2;
    while (one != 0) begin
      if (n >= res + one) begin
        n -= res + one;
        res = (res >> 1) + one;
      end else begin
        res >>= 1;
      end
      one >>= 2;
    end
    return res;
  endfunction

  function automatic ray_result_t cast_ray(int sx, int sy, logic signed [15:0] vx,
                                           logic signed [15:0] vy);
    ray_result_t r;
    int w, h, px, py, stx, sty, dx, dy;
    longint ax, ay, kx, ky, guard;
    longint unsigned d2, n, s, rounded;
    bit left;
    w = clamp_dim(cols_reg);
    h = clamp_dim(rows_reg);
    stx = (vx >= 0) ? 1 : -1;
    sty = (vy >= 0) ? 1 : -1;
    ax = (vx < 0) ? -longint'(vx) : longint'(vx);
    ay = (vy < 0) ? -longint'(vy) : longint'(vy);
    px = sx;
    py = sy;
    kx = 1;
    ky = 1;
    left = 1'b0;
    for (guard = 0; ; guard++) begin
      if (px < 0 || px >= w || py < 0 || py >= h) begin
        left = 1'b1;
        break;
      end
      if (!free_cells[py * GRID_DIM + px]) break;
      if (guard >= 2 * GRID_DIM + 2) begin
        left = 1'b1;
        break;
      end
      if (ax != 0 && (ay == 0 || kx * ay < ky * ax)) begin
        kx++;
        px += stx;
      end else begin
        ky++;
        py += sty;
      end
    end
    dx = px - sx;
    dy = py - sy;
    d2 = longint'(dx) * dx + longint'(dy) * dy;
    n = d2 << 16;
    s = int_root(n);
    rounded = s + ((n - s * s > s) ? 1 : 0);
    if (d2 > 262143) d2 = 262143;
    if (rounded > 131071) rounded = 131071;
    r.distance = rounded[16:0];
    r.distance_squared = d2[17:0];
    r.end_x = px[9:0];
    r.end_y = py[9:0];
    r.left_grid = left;
    return r;
  endfunction

  task automatic send_word(logic op, int x, int y, logic fr, logic signed [15:0] vx,
                           logic signed [15:0] vy);
    int cx, cy;
    cx = x & 255;
    cy = y & 255;
    while (!calm && $urandom_range(99) < 8) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_cell_x <= cx[7:0];
    in_cell_y <= cy[7:0];
    in_cell_free <= fr;
    in_dir_x <= vx;
    in_dir_y <= vy;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (op == OP_WRITE) free_cells[cy * GRID_DIM + cx] = fr;
    else pending_rays.push_back(cast_ray(cx, cy, vx, vy));
    @(negedge clk);
  endtask

  task automatic write_cell(int x, int y, logic fr);
    send_word(OP_WRITE, x, y, fr, 16'($urandom), 16'($urandom));
  endtask

  task automatic query(int x, int y, logic signed [15:0] vx, logic signed [15:0] vy);
    send_word(OP_QUERY, x, y, 1'($urandom), vx, vy);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_rays.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic set_dims(int unsigned cols, int unsigned rows);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= 1'b0;
    cfg_data <= cols[8:0];
    @(negedge clk);
    cfg_index <= 1'b1;
    cfg_data <= rows[8:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    cols_reg = cols[8:0];
    rows_reg = rows[8:0];
  endtask

  function automatic logic signed [15:0] rand_dir();
    case ($urandom_range(5))
      0: return 16'sd0;
      1: return 16'sh7fff;
      2: return 16'sh8000;
      3: return $urandom_range(1) ? 16'sd1 : -16'sd1;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic test_directed();
    query(0, 0, 16'sd100, 16'sd0);
    query(255, 255, 16'sh7fff, 16'sh7fff);
    for (int i = 0; i < 8; i++) write_cell(10 + i, 20, 1'b1);
    write_cell(255, 255, 1'b1);
    write_cell(0, 255, 1'b1);
    query(10, 20, 16'sd1000, 16'sd0);
    query(17, 20, 16'sh8000, 16'sd0);
    query(12, 20, 16'sd0, 16'sd0);
    query(12, 20, 16'sd0, -16'sd5);
    query(255, 255, 16'sh7fff, 16'sh8000);
    query(0, 255, 16'sh8000, 16'sh7fff);
    query(13, 20, 16'sd300, 16'sd300);
    set_dims(5, 0);
    query(10, 20, 16'sd1, 16'sd0);
    query(3, 0, 16'sd0, 16'sd0);
    set_dims(511, 300);
    query(10, 20, 16'sd1, 16'sd0);
  endtask

  task automatic test_open_area(int unsigned cols, int unsigned rows, int count);
    int bx, by;
    set_dims(cols, rows);
    bx = $urandom_range(0, 200);
    by = $urandom_range(0, 200);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 55)
        write_cell(bx + $urandom_range(40), by + $urandom_range(40),
                   $urandom_range(99) < 85);
      else if ($urandom_range(9) == 0)
        query($urandom, $urandom, rand_dir(), rand_dir());
      else
        query(bx + $urandom_range(40), by + $urandom_range(40), rand_dir(), rand_dir());
    end
  endtask

  task automatic test_backpressure();
    calm = 1'b1;
    fork
      begin
        sink_hold = 1'b1;
        repeat (300) @(negedge clk);
        sink_hold = 1'b0;
      end
      for (int i = 0; i < 12; i++) query(20 + i, 20, 16'sd5, 16'sd7);
    join
    calm = 1'b0;
    drain();
    for (int i = 0; i < 6; i++) query($urandom, $urandom, rand_dir(), rand_dir());
  endtask

  task automatic test_long_calm();
    calm = 1'b1;
    test_open_area(64, 64, 120);
    calm = 1'b0;
  endtask

  always @(negedge clk) begin
    if (sink_hold) out_ready <= 1'b0;
    else out_ready <= calm || ($urandom_range(99) >= 8);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_rays.size() == 0) begin
        $error("unexpected result word");
        errors++;
      end else begin
        ray_result_t e;
        e = pending_rays.pop_front();
        if (out_distance !== e.distance) begin
          $error("distance exp %0d got %0d", e.distance, out_distance);
          errors++;
        end
        if (out_distance_squared !== e.distance_squared) begin
          $error("distance_squared exp %0d got %0d", e.distance_squared,
                 out_distance_squared);
          errors++;
        end
        if (out_end_x !== e.end_x) begin
          $error("end_x exp %0d got %0d", $signed(e.end_x), out_end_x);
          errors++;
        end
        if (out_end_y !== e.end_y) begin
          $error("end_y exp %0d got %0d", $signed(e.end_y), out_end_y);
          errors++;
        end
        if (out_left_grid !== e.left_grid) begin
          $error("left_grid exp %0d got %0d", e.left_grid, out_left_grid);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 300000) begin
      $display("grid_ray_free_distance_unit regression: fail");
      $finish;
    end
  end

  initial begin
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_backpressure();
    test_open_area(256, 256, 300);
    test_open_area(1, 256, 80);
    test_open_area(256, 1, 80);
    test_long_calm();
    test_open_area(37, 200, 200);
    test_open_area(256, 256, 280);
    drain();
    if (errors == 0) $display("grid_ray_free_distance_unit regression: pass");
    else $display("grid_ray_free_distance_unit regression: fail");
    $finish;
  end
endmodule
